FILE: rtl/mufr_pkg.sv
// shared types and constants for the mctp over usb frame receiver
package mufr_pkg;

  localparam logic [7:0] SIG_FIRST   = 8'h1A;
  localparam logic [7:0] SIG_SECOND  = 8'hB4;
  localparam logic [7:0] HDR_BYTES   = 8'd4;
  localparam logic [7:0] MAX_LEN_RST = 8'd255;

  typedef struct packed {
    logic [7:0] data;
    logic       abort;
  } mufr_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       last;
    logic       bad_length;
    logic       empty_frame;
    logic       aborted;
  } mufr_res_t;

endpackage

FILE: rtl/mctp_usb_frame_receiver.sv
// mctp over usb receive deframer, top level
// Takes one received byte per item and finds frames that open with the
// signature 1A B4, a reserved byte and a total-length byte. Each payload byte
// comes out as one result item, the final one marked last; a rejected length,
// an empty frame and an abort during the payload each give one flag-only item.
// One item is accepted every cycle while the result side keeps up; each result
// passes through the input register and then the result register. The user must
// write max_frame_len through cfg_wr_en and cfg_wr_data only while no item is in
// flight; the block itself does not enforce this.
module mctp_usb_frame_receiver import mufr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_abort,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_byte_valid,
  output logic       out_last,
  output logic       out_bad_length,
  output logic       out_empty_frame,
  output logic       out_aborted
);

  logic [7:0] max_frame_len_r;
  mufr_item_t in_item, item;
  mufr_res_t  res, out_res;
  logic       item_valid, adv, res_valid;

  assign in_item.data  = in_byte;
  assign in_item.abort = in_abort;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_len_r <= MAX_LEN_RST;
    end else if (cfg_wr_en) begin
      max_frame_len_r <= cfg_wr_data;
    end
  end

  mufr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  mufr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (item_valid && adv),
    .item      (item),
    .max_len   (max_frame_len_r),
    .res_valid (res_valid),
    .res       (res)
  );

  mufr_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res_valid  (res_valid),
    .res        (res),
    .adv        (adv),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign out_payload_byte = out_res.payload_byte;
  assign out_byte_valid   = out_res.byte_valid;
  assign out_last         = out_res.last;
  assign out_bad_length   = out_res.bad_length;
  assign out_empty_frame  = out_res.empty_frame;
  assign out_aborted      = out_res.aborted;

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_byte_valid, out_bad_length, out_empty_frame, out_aborted}))
    else $error("result item carries more or fewer than one kind");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_frame |-> out_last)
    else $error("empty frame without last");

  a_flag_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_payload_byte == 8'd0)
    else $error("flag-only item with nonzero payload byte");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_valid && out_valid && out_stall)
    else $error("input stalled without a blocked result");

endmodule

FILE: rtl/mufr_in_reg.sv
// input register stage for received items
module mufr_in_reg import mufr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  mufr_item_t in_item,
  input  logic       adv,
  output logic       item_valid,
  output mufr_item_t item
);

  logic       valid_r, valid_nxt;
  mufr_item_t item_r;

  assign in_stall   = valid_r && !adv;
  assign valid_nxt  = in_valid;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

FILE: rtl/mufr_parser.sv
// frame parser state machine, one item per cycle while fire is high
module mufr_parser import mufr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  mufr_item_t item,
  input  logic [7:0] max_len,
  output logic       res_valid,
  output mufr_res_t  res
);

  typedef enum logic [2:0] {
    PH_SIG0 = 3'd0,
    PH_SIG1 = 3'd1,
    PH_RSVD = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] byte_index_r, byte_index_nxt;
  logic [7:0] payload_len_r, payload_len_nxt;
  logic [7:0] idx_inc;

  assign idx_inc = byte_index_r + 8'd1;

  always_comb begin
    phase_nxt       = phase_r;
    byte_index_nxt  = byte_index_r;
    payload_len_nxt = payload_len_r;
    res_valid       = 1'b0;
    res             = '0;
    if (item.abort) begin
      phase_nxt       = PH_SIG0;
      byte_index_nxt  = 8'd0;
      payload_len_nxt = 8'd0;
      if (phase_r == PH_DATA) begin
        res_valid   = 1'b1;
        res.aborted = 1'b1;
      end
    end else begin
      unique case (phase_r)
        PH_SIG1: begin
          if (item.data == SIG_SECOND) begin
            phase_nxt = PH_RSVD;
          end else if (item.data == SIG_FIRST) begin
            phase_nxt = PH_SIG1;
          end else begin
            phase_nxt = PH_SIG0;
          end
        end
        PH_RSVD: begin
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if (item.data < HDR_BYTES || item.data > max_len) begin
            phase_nxt       = PH_SIG0;
            byte_index_nxt  = 8'd0;
            payload_len_nxt = 8'd0;
            res_valid       = 1'b1;
            res.bad_length  = 1'b1;
          end else if (item.data == HDR_BYTES) begin
            phase_nxt       = PH_SIG0;
            byte_index_nxt  = 8'd0;
            payload_len_nxt = 8'd0;
            res_valid       = 1'b1;
            res.last        = 1'b1;
            res.empty_frame = 1'b1;
          end else begin
            phase_nxt       = PH_DATA;
            byte_index_nxt  = 8'd0;
            payload_len_nxt = item.data - HDR_BYTES;
          end
        end
        PH_DATA: begin
          res_valid        = 1'b1;
          res.payload_byte = item.data;
          res.byte_valid   = 1'b1;
          if (idx_inc >= payload_len_r) begin
            res.last        = 1'b1;
            phase_nxt       = PH_SIG0;
            byte_index_nxt  = 8'd0;
            payload_len_nxt = 8'd0;
          end else begin
            byte_index_nxt = idx_inc;
          end
        end
        default: begin
          phase_nxt = (item.data == SIG_FIRST) ? PH_SIG1 : PH_SIG0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_SIG0;
      byte_index_r  <= 8'd0;
      payload_len_r <= 8'd0;
    end else if (fire) begin
      phase_r       <= phase_nxt;
      byte_index_r  <= byte_index_nxt;
      payload_len_r <= payload_len_nxt;
    end
  end

endmodule

FILE: rtl/mufr_out_reg.sv
// result register stage
module mufr_out_reg import mufr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_valid,
  input  logic      res_valid,
  input  mufr_res_t res,
  output logic      adv,
  output logic      out_valid,
  input  logic      out_stall,
  output mufr_res_t out_res
);

  logic      valid_r, valid_nxt;
  mufr_res_t res_r;

  assign adv       = !valid_r || !out_stall;
  assign valid_nxt = item_valid && res_valid;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && valid_nxt) begin
      res_r <= res;
    end
  end

endmodule

FILE: tb/tb_mctp_usb_frame_receiver.sv
// testbench for mctp_usb_frame_receiver: random byte streams checked against a predictor
`timescale 1ns / 1ps

module tb_mctp_usb_frame_receiver;
  import mufr_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CHUNK_ITEMS  = 220;

  typedef enum logic [2:0] {
    PH_SIG_FIRST,
    PH_SIG_SECOND,
    PH_RSVD,
    PH_LEN,
    PH_PAYLOAD
  } rx_phase_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_abort = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_payload_byte;
  logic       out_byte_valid;
  logic       out_last;
  logic       out_bad_length;
  logic       out_empty_frame;
  logic       out_aborted;

  // predictor state
  rx_phase_t  rx_phase = PH_SIG_FIRST;
  logic [7:0] rx_count = 8'd0;
  logic [7:0] rx_plen = 8'd0;
  logic [7:0] frame_max = MAX_LEN_RST;

  mufr_item_t  byte_stream[$];
  mufr_res_t   expected_deframed[$];
  mufr_item_t  next_item;
  mufr_res_t   predicted;
  mufr_res_t   want;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned stream_items = 0;
  int unsigned errors = 0;

  mctp_usb_frame_receiver i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_abort         (in_abort),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_byte_valid   (out_byte_valid),
    .out_last         (out_last),
    .out_bad_length   (out_bad_length),
    .out_empty_frame  (out_empty_frame),
    .out_aborted      (out_aborted)
  );

  always #4 clk = ~clk;

  function automatic bit deframe_step(input logic [7:0] b, input logic ab,
                                      output mufr_res_t r);
    bit hit;
    hit = 1'b0;
    r = '0;
    if (ab) begin
      if (rx_phase == PH_PAYLOAD) begin
        r.aborted = 1'b1;
        hit = 1'b1;
      end
      rx_phase = PH_SIG_FIRST;
      rx_count = 8'd0;
      rx_plen = 8'd0;
      return hit;
    end
    case (rx_phase)
      PH_SIG_SECOND: begin
        if (b == SIG_SECOND) rx_phase = PH_RSVD;
        else if (b == SIG_FIRST) rx_phase = PH_SIG_SECOND;
        else rx_phase = PH_SIG_FIRST;
      end
      PH_RSVD: rx_phase = PH_LEN;
      PH_LEN: begin
        if (b < HDR_BYTES || b > frame_max) begin
          r.bad_length = 1'b1;
          hit = 1'b1;
        end else if (b == HDR_BYTES) begin
          r.last = 1'b1;
          r.empty_frame = 1'b1;
          hit = 1'b1;
        end else begin
          rx_plen = b - HDR_BYTES;
          rx_count = 8'd0;
          rx_phase = PH_PAYLOAD;
        end
        if (hit) begin
          rx_phase = PH_SIG_FIRST;
          rx_count = 8'd0;
          rx_plen = 8'd0;
        end
      end
      PH_PAYLOAD: begin
        rx_count = rx_count + 8'd1;
        r.payload_byte = b;
        r.byte_valid = 1'b1;
        hit = 1'b1;
        if (rx_count >= rx_plen) begin
          r.last = 1'b1;
          rx_phase = PH_SIG_FIRST;
          rx_count = 8'd0;
          rx_plen = 8'd0;
        end
      end
      default: begin
        if (b == SIG_FIRST) rx_phase = PH_SIG_SECOND;
        else rx_phase = PH_SIG_FIRST;
      end
    endcase
    return hit;
  endfunction

  task automatic check_field(input string fname, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want_v, got_v);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (deframe_step(in_byte, in_abort, predicted))
          expected_deframed.push_back(predicted);
      end
      if (!in_valid || !in_stall) begin
        if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = byte_stream.pop_front();
          in_valid <= 1'b1;
          in_byte <= next_item.data;
          in_abort <= next_item.abort;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_deframed.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected item, expected none, actual %h %b%b%b%b%b", $time,
                   out_payload_byte, out_byte_valid, out_last, out_bad_length,
                   out_empty_frame, out_aborted);
      end else begin
        want = expected_deframed.pop_front();
        check_field("payload_byte", want.payload_byte, out_payload_byte);
        check_field("byte_valid", 8'(want.byte_valid), 8'(out_byte_valid));
        check_field("last", 8'(want.last), 8'(out_last));
        check_field("bad_length", 8'(want.bad_length), 8'(out_bad_length));
        check_field("empty_frame", 8'(want.empty_frame), 8'(out_empty_frame));
        check_field("aborted", 8'(want.aborted), 8'(out_aborted));
      end
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_done) begin
      hold_done <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic ab);
    mufr_item_t itm;
    itm.data = b;
    itm.abort = ab;
    byte_stream.push_back(itm);
    stream_items++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (byte_stream.size() != 0 || in_valid || expected_deframed.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_max_frame_len(input logic [7:0] v);
    wait_drained();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    frame_max = v;
  endtask

  task automatic add_frame();
    mufr_item_t  frm[$];
    mufr_item_t  itm;
    int unsigned kind;
    int unsigned len;
    int unsigned hi;
    int unsigned cut;
    kind = $urandom_range(99);
    if (kind >= 95) begin
      repeat ($urandom_range(5, 1)) push_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
      return;
    end
    if ($urandom_range(4) == 0)
      repeat ($urandom_range(3, 1)) push_byte(8'($urandom_range(255)), 1'b0);
    itm.abort = 1'b0;
    itm.data = SIG_FIRST;
    frm.push_back(itm);
    if ($urandom_range(7) == 0) frm.push_back(itm);
    itm.data = SIG_SECOND;
    frm.push_back(itm);
    itm.data = 8'($urandom_range(255));
    frm.push_back(itm);
    if (kind >= 75 && kind < 85) begin
      if (frame_max == 8'd255 || $urandom_range(1) == 0) len = $urandom_range(3, 0);
      else len = $urandom_range(255, int'(frame_max) + 1);
      itm.data = 8'(len);
      frm.push_back(itm);
    end else begin
      hi = frame_max;
      if (hi <= 4) len = 4;
      else if ($urandom_range(19) == 0) len = hi;
      else len = $urandom_range(hi < 16 ? hi : 16, 4);
      itm.data = 8'(len);
      frm.push_back(itm);
      repeat (len - 4) begin
        itm.data = 8'($urandom_range(255));
        frm.push_back(itm);
      end
    end
    if (kind >= 85) begin
      cut = $urandom_range(frm.size() - 1);
      for (int k = 0; k < cut; k++) push_byte(frm[k].data, 1'b0);
      push_byte(frm[cut].data, 1'b1);
    end else begin
      foreach (frm[k]) push_byte(frm[k].data, 1'b0);
    end
  endtask

  task automatic run_chunk(input logic [7:0] max_len, input int unsigned s_idle,
                           input int unsigned r_idle, input bit long_hold);
    set_max_frame_len(max_len);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    if (long_hold) hold_reqs <= hold_reqs + 1;
    stream_items = 0;
    while (stream_items < CHUNK_ITEMS) add_frame();
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 35;
    recv_idle_pct = 79;

    // two byte payload, reset maximum
    push_byte(SIG_FIRST, 1'b0);
    push_byte(SIG_SECOND, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h06, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    // empty frame
    push_byte(SIG_FIRST, 1'b0);
    push_byte(SIG_SECOND, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(HDR_BYTES, 1'b0);
    // repeated first signature byte, then a short length
    push_byte(SIG_FIRST, 1'b0);
    push_byte(SIG_FIRST, 1'b0);
    push_byte(SIG_SECOND, 1'b0);
    push_byte(8'h33, 1'b0);
    push_byte(8'h03, 1'b0);
    // abort during payload
    push_byte(SIG_FIRST, 1'b0);
    push_byte(SIG_SECOND, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h07, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(SIG_FIRST, 1'b1);
    // abort while hunting, broken signature
    push_byte(SIG_FIRST, 1'b1);
    push_byte(SIG_FIRST, 1'b0);
    push_byte(8'h00, 1'b0);
    wait_drained();

    run_chunk(8'd4, 35, 79, 1'b0);
    run_chunk(8'($urandom_range(254, 5)), 35, 79, 1'b0);
    run_chunk(8'd255, 79, 35, 1'b0);
    run_chunk(8'd20, 79, 35, 1'b0);
    run_chunk(8'd255, 0, 0, 1'b1);
    run_chunk(8'($urandom_range(254, 5)), 0, 0, 1'b0);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
